>>> src/rabs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the running-average background subtractor.
// No dependencies; every other file except rabs_ram imports this package.
package rabs_pkg;

  // Frame geometry and store layout
  localparam int FRAME_PIXELS = 65536;
  localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int IDX_W        = 16;
  localparam int RANGE_W      = 23;
  localparam int PIX_W        = 8;
  localparam int NUM_CH       = 3;
  localparam int ENTRY_W      = PIX_W * NUM_CH;

  // Blend arithmetic, alpha in Q1.8
  localparam int BLEND_W   = 9;
  localparam int BSUM_W    = 17;
  localparam logic [BLEND_W-1:0] BLEND_ONE  = 9'd256;
  localparam logic [BSUM_W-1:0]  BLEND_HALF = 17'd128;
  localparam logic [PIX_W-1:0]   PIX_MAX    = 8'd255;

  // BT.601 luma weights in Q14
  localparam int GSUM_W    = 22;
  localparam int GRAY_FRAC = 14;
  localparam logic [13:0]       GRAY_WB    = 14'd1868;
  localparam logic [13:0]       GRAY_WG    = 14'd9617;
  localparam logic [13:0]       GRAY_WR    = 14'd4899;
  localparam logic [GSUM_W-1:0] GRAY_ROUND = 22'd8192;

  // Queues between and behind the two halves
  localparam int CMD_Q_DEPTH = 2;
  localparam int CMD_Q_PTR_W = 1;
  localparam int CMD_Q_CNT_W = 2;
  localparam int OUT_Q_DEPTH = 4;
  localparam int OUT_Q_PTR_W = 2;
  localparam int OUT_Q_CNT_W = 3;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_BLEND_RATE = 2'd1,
    CFG_SELECTIVE  = 2'd2,
    CFG_COLOR_MODE = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_SUBTRACT = 1'b1
  } op_t;

  typedef struct packed {
    logic [PIX_W-1:0]   threshold;
    logic [BLEND_W-1:0] blend_rate;
    logic               selective;
    logic               color_mode;
  } cfg_t;

  // One classified request handed from front to back
  typedef struct packed {
    op_t                op;
    logic               in_range;
    logic               color;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] pix;
  } cmd_t;

endpackage

>>> src/running_average_background_subtract_top.sv
`timescale 1ns / 1ps
// Top level of the running-average background subtractor: configuration
// registers and the front/queue/back halves. Depends on rabs_pkg and all rabs_* modules.
//
// Sustained rate is one pixel per clock while out_ready stays high: each pixel
// makes one read and at most one write of its background entry, and the store's
// separate read and write ports serve both in the same cycle. A pixel's
// foreground flag passes the front register, the request queue, the store read
// with blend and compare, and the result queue. The store is not cleared after
// reset, so there is no start-up pass; subtracting at an index that was never
// loaded gives an unspecified flag. Configuration writes are taken at any time
// but must only be issued while no pixel is in flight.
module running_average_background_subtract_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [rabs_pkg::IDX_W-1:0]       pixel_index,
  input  logic [rabs_pkg::PIX_W-1:0]       blue,
  input  logic [rabs_pkg::PIX_W-1:0]       green,
  input  logic [rabs_pkg::PIX_W-1:0]       red,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             foreground,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rabs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rabs_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= 8'd25;
      cfg.blend_rate <= 9'd13;
      cfg.selective  <= 1'b1;
      cfg.color_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:  cfg.threshold  <= cfg_data[PIX_W-1:0];
        CFG_BLEND_RATE: cfg.blend_rate <= cfg_data[BLEND_W-1:0];
        CFG_SELECTIVE:  cfg.selective  <= cfg_data[0];
        CFG_COLOR_MODE: cfg.color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rabs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .pixel_index (pixel_index),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .cmd         (front_cmd),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready)
  );

  rabs_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  rabs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (back_cmd),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .foreground (foreground)
  );

endmodule

>>> src/rabs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rabs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/rabs_front.sv
`timescale 1ns / 1ps
// Front half: takes pixel requests, range-checks the index and reduces to
// luma in gray mode. Depends on rabs_pkg.
module rabs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  rabs_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [rabs_pkg::IDX_W-1:0]   pixel_index,
  input  logic [rabs_pkg::PIX_W-1:0]   blue,
  input  logic [rabs_pkg::PIX_W-1:0]   green,
  input  logic [rabs_pkg::PIX_W-1:0]   red,
  output rabs_pkg::cmd_t               cmd,
  output logic                         cmd_valid,
  input  logic                         cmd_ready
);
  import rabs_pkg::*;

  logic [GSUM_W-1:0] gsum;
  logic [PIX_W-1:0]  luma;
  cmd_t              cmd_next;
  logic              accept;

  assign in_ready = !cmd_valid || cmd_ready;
  assign accept   = in_valid && in_ready;

  // BT.601 luma, rounded
  assign gsum = GSUM_W'(GRAY_WB) * GSUM_W'(blue)
              + GSUM_W'(GRAY_WG) * GSUM_W'(green)
              + GSUM_W'(GRAY_WR) * GSUM_W'(red)
              + GRAY_ROUND;
  assign luma = gsum[GRAY_FRAC +: PIX_W];

  // Classify the request
  always_comb begin
    cmd_next.op       = op_t'(op);
    cmd_next.in_range = {{(RANGE_W-IDX_W){1'b0}}, pixel_index} < RANGE_W'(FRAME_PIXELS);
    cmd_next.color    = cfg.color_mode;
    cmd_next.addr     = ADDR_W'(pixel_index);
    if (cfg.color_mode) begin
      cmd_next.pix = {red, green, blue};
    end else begin
      cmd_next.pix = {{(ENTRY_W-PIX_W){1'b0}}, luma};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

>>> src/rabs_cmd_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified requests between the front and back halves.
// Depends on rabs_pkg.
module rabs_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  rabs_pkg::cmd_t push_cmd,
  input  logic           push_valid,
  output logic           push_ready,
  output rabs_pkg::cmd_t pop_cmd,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import rabs_pkg::*;

  cmd_t                   entries [CMD_Q_DEPTH];
  logic [CMD_Q_PTR_W-1:0] wr_ptr;
  logic [CMD_Q_PTR_W-1:0] rd_ptr;
  logic [CMD_Q_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign push_ready = count != CMD_Q_CNT_W'(CMD_Q_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> src/rabs_back.sv
`timescale 1ns / 1ps
// Back half: reads the background entry, decides foreground, blends and
// writes back, and queues the result. Depends on rabs_pkg and rabs_ram.
module rabs_back (
  input  logic           clk,
  input  logic           rst,
  input  rabs_pkg::cfg_t cfg,
  input  rabs_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           foreground
);
  import rabs_pkg::*;

  // Read stage and compute stage
  logic                   pop;
  logic                   b1_valid;
  cmd_t                   b1_cmd;
  logic [ENTRY_W-1:0]     rd_data;
  logic [ENTRY_W-1:0]     bkg_word;

  // Last write, for a same-address request right behind it
  logic                   fwd_valid;
  logic [ADDR_W-1:0]      fwd_addr;
  logic [ENTRY_W-1:0]     fwd_data;

  logic [BLEND_W-1:0]     alpha;
  logic [BLEND_W-1:0]     alpha_inv;
  logic [PIX_W-1:0]       pc   [NUM_CH];
  logic [PIX_W-1:0]       bc   [NUM_CH];
  logic [PIX_W-1:0]       diff [NUM_CH];
  logic [BSUM_W-1:0]      bsum [NUM_CH];
  logic [ENTRY_W-1:0]     blend_word;
  logic                   fg;
  logic                   wr_en;
  logic [ENTRY_W-1:0]     wr_data;

  // Result queue
  logic                   out_q [OUT_Q_DEPTH];
  logic [OUT_Q_PTR_W-1:0] oq_wr_ptr;
  logic [OUT_Q_PTR_W-1:0] oq_rd_ptr;
  logic [OUT_Q_CNT_W-1:0] oq_count;
  logic                   oq_pop;

  // Issue only when the result queue has room for everything in flight
  assign cmd_ready = (oq_count + OUT_Q_CNT_W'(b1_valid)) < OUT_Q_CNT_W'(OUT_Q_DEPTH);
  assign pop       = cmd_valid && cmd_ready;

  rabs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAME_PIXELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b1_cmd.addr),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (cmd.addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_cmd <= cmd;
    end
  end

  assign bkg_word = (fwd_valid && fwd_addr == b1_cmd.addr) ? fwd_data : rd_data;

  // Alpha saturates at 1.0
  assign alpha     = (cfg.blend_rate > BLEND_ONE) ? BLEND_ONE : cfg.blend_rate;
  assign alpha_inv = BLEND_ONE - alpha;

  // Per-channel difference test and blend; gray mode uses channel 0 only
  always_comb begin
    logic any_over;
    logic active;
    logic [BLEND_W-1:0] v;
    any_over   = 1'b0;
    blend_word = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      active  = (c == 0) || b1_cmd.color;
      pc[c]   = b1_cmd.pix[c*PIX_W +: PIX_W];
      bc[c]   = active ? bkg_word[c*PIX_W +: PIX_W] : '0;
      diff[c] = (pc[c] > bc[c]) ? (pc[c] - bc[c]) : (bc[c] - pc[c]);
      if (active && diff[c] > cfg.threshold) begin
        any_over = 1'b1;
      end
      bsum[c] = BSUM_W'(alpha) * BSUM_W'(pc[c])
              + BSUM_W'(alpha_inv) * BSUM_W'(bc[c])
              + BLEND_HALF;
      v = bsum[c][PIX_W +: BLEND_W];
      if (active) begin
        blend_word[c*PIX_W +: PIX_W] = v[PIX_W] ? PIX_MAX : v[PIX_W-1:0];
      end
    end
    fg = b1_cmd.in_range && (b1_cmd.op == OP_SUBTRACT) && any_over;
  end

  // Loads always write; subtracts skip the update on selective foreground
  assign wr_en   = b1_valid && b1_cmd.in_range
                && ((b1_cmd.op == OP_LOAD) || !(cfg.selective && fg));
  assign wr_data = (b1_cmd.op == OP_LOAD) ? b1_cmd.pix : blend_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= b1_cmd.addr;
      fwd_data <= wr_data;
    end
  end

  // Result queue
  assign out_valid  = oq_count != '0;
  assign foreground = out_q[oq_rd_ptr];
  assign oq_pop     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= '0;
      oq_rd_ptr <= '0;
      oq_count  <= '0;
    end else begin
      if (b1_valid) begin
        oq_wr_ptr <= oq_wr_ptr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_ptr <= oq_rd_ptr + 1'b1;
      end
      if (b1_valid && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !b1_valid) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      out_q[oq_wr_ptr] <= fg;
    end
  end

`ifndef SYNTHESIS
  // A finished request always finds room in the result queue
  assert property (@(posedge clk) disable iff (rst)
    b1_valid |-> (oq_count < OUT_Q_CNT_W'(OUT_Q_DEPTH)) || oq_pop)
    else $error("result queue overflow");

  // Out-of-frame requests never touch the store
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> b1_cmd.in_range)
    else $error("store write for out-of-frame index");

  // A load never reports foreground
  assert property (@(posedge clk) disable iff (rst)
    (b1_valid && b1_cmd.op == OP_LOAD) |-> !fg)
    else $error("foreground flagged on load");

  // Every issued read reaches the compute stage next cycle
  assert property (@(posedge clk) disable iff (rst)
    pop |=> b1_valid)
    else $error("issued request lost before compute");
`endif

endmodule
